// File: design/tpa_pkg.sv
package tpa_pkg;

    localparam int INDEX_BITS = 20;
    localparam int COUNT_BITS = 32;

    typedef enum logic [1:0] {
        KIND_LIST  = 2'd0,
        KIND_STRIP = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    typedef struct packed {
        logic [INDEX_BITS-1:0] vertex_index;
        logic [1:0]            primitive_kind;
        logic                  starts_face;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_BITS-1:0] corner_first;
        logic [INDEX_BITS-1:0] corner_second;
        logic [INDEX_BITS-1:0] corner_third;
        logic [COUNT_BITS-1:0] triangle_number;
    } t_out_word;

    // Assembly state carried from one vertex to the next
    typedef struct packed {
        logic [INDEX_BITS-1:0] older_vertex;
        logic [INDEX_BITS-1:0] newer_vertex;
        logic [1:0]            vertices_seen;
        logic                  winding_kept;
        t_kind                 current_kind;
        logic [COUNT_BITS-1:0] triangle_count;
    } t_asm_state;

endpackage

// File: design/tpa_step.sv
module tpa_step
    import tpa_pkg::*;
(
    input  t_asm_state i_state,
    input  t_in_word   i_word,
    output t_asm_state o_state,
    output logic       o_emit,
    output t_out_word  o_word
);

    t_kind                 face_kind;
    logic [1:0]            seen;
    logic                  wind;
    logic [INDEX_BITS-1:0] v;

    // Resolve face start: latch kind, restart vertex count and winding
    always_comb begin
        v = i_word.vertex_index;
        if (i_word.starts_face) begin
            case (i_word.primitive_kind)
                KIND_LIST:  face_kind = KIND_LIST;
                KIND_STRIP: face_kind = KIND_STRIP;
                default:    face_kind = KIND_OTHER;
            endcase
            seen = 2'd0;
            wind = 1'b1;
        end else begin
            face_kind = i_state.current_kind;
            seen      = i_state.vertices_seen;
            wind      = i_state.winding_kept;
        end
    end

    // Advance the held vertices and close a triangle when one is complete
    always_comb begin
        o_state               = i_state;
        o_state.current_kind  = face_kind;
        o_state.vertices_seen = seen;
        o_state.winding_kept  = wind;
        o_emit                = 1'b0;
        o_word.corner_first   = i_state.older_vertex;
        o_word.corner_second  = i_state.newer_vertex;
        o_word.corner_third   = v;
        o_word.triangle_number = i_state.triangle_count;

        if (face_kind == KIND_LIST || face_kind == KIND_STRIP) begin
            case (seen)
                2'd0: begin
                    o_state.older_vertex  = v;
                    o_state.vertices_seen = 2'd1;
                end
                2'd1: begin
                    o_state.newer_vertex  = v;
                    o_state.vertices_seen = 2'd2;
                end
                default: begin
                    o_emit                 = 1'b1;
                    o_state.triangle_count = i_state.triangle_count + COUNT_BITS'(1);
                    if (face_kind == KIND_LIST) begin
                        o_state.vertices_seen = 2'd0;
                    end else begin
                        // swap the older corners on alternate strip triangles
                        if (!wind) begin
                            o_word.corner_first  = i_state.newer_vertex;
                            o_word.corner_second = i_state.older_vertex;
                        end
                        o_state.older_vertex = i_state.newer_vertex;
                        o_state.newer_vertex = v;
                        o_state.winding_kept = ~wind;
                    end
                end
            endcase
        end
    end

endmodule

// File: design/triangle_primitive_assembly_top.sv
// Triangle primitive assembly.
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one vertex word:
// its index, the primitive kind of its face and a face-start flag. Output
// channel (o_out_valid / i_out_ready / o_out_word) carries one indexed triangle
// with a running 32-bit triangle number.
// Triangle lists close a triangle on every third vertex of a face; strips close
// one on every vertex after the second, alternating winding. Other kinds emit
// nothing.
// Throughput: one vertex per cycle while no held triangle waits untaken. The
// per-vertex update is a few muxes between the assembly state register and
// the output word register. A triangle appears on o_out_valid in the cycle
// after the vertex that closes it is accepted.
// When the receiver stalls, the output register holds its word and the input
// stays open only if the held word is taken in the same cycle.
// Reset (synchronous, active low) clears the held vertices, the triangle count
// and the output valid, and sets the face kind to "other" so that vertices
// before the first face start are dropped.
module triangle_primitive_assembly_top
    import tpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_asm_state r_state;
    t_asm_state n_state;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_out_word  step_word;
    logic       step_emit;
    logic       in_acc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    tpa_step u_step (
        .i_state (r_state),
        .i_word  (i_in_word),
        .o_state (n_state),
        .o_emit  (step_emit),
        .o_word  (step_word)
    );

    // Advance assembly state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.older_vertex   <= '0;
            r_state.newer_vertex   <= '0;
            r_state.vertices_seen  <= 2'd0;
            r_state.winding_kept   <= 1'b1;
            r_state.current_kind   <= KIND_OTHER;
            r_state.triangle_count <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Hold the result until taken; drop valid when taken with nothing new
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= in_acc && step_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step_emit) begin
            r_out_word <= step_word;
        end
    end

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.vertices_seen != 2'd3)
        else $error("vertex count out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && step_emit |=>
            r_state.triangle_count == $past(r_state.triangle_count) + COUNT_BITS'(1))
        else $error("triangle count did not advance");

    a_other_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_word.starts_face && r_state.current_kind == KIND_OTHER
            |-> !step_emit)
        else $error("triangle from a face of other kind");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc))
        else $error("result without an accepted vertex");

    a_number_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && step_emit |=>
            r_out_word.triangle_number + COUNT_BITS'(1) == r_state.triangle_count)
        else $error("triangle number out of step with count");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import tpa_pkg::*;

    localparam int IDLE_PERCENT = 34;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 800;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
    // Unused kind code, handled like the other kind
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // Shadow of the assembly state
    logic [INDEX_BITS-1:0] held_older;
    logic [INDEX_BITS-1:0] held_newer;
    logic [1:0]            held_count;
    logic                  keep_winding;
    t_kind                 face_kind;
    logic [COUNT_BITS-1:0] triangles_made;

    t_out_word pending_triangles[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    bit        no_idle = 1'b0;

    triangle_primitive_assembly_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #2 i_clk = ~i_clk;

    // Queue one triangle with the current running number
    task automatic close_triangle(input logic [INDEX_BITS-1:0] a,
                                  input logic [INDEX_BITS-1:0] b,
                                  input logic [INDEX_BITS-1:0] c);
        t_out_word t;
        t.corner_first    = a;
        t.corner_second   = b;
        t.corner_third    = c;
        t.triangle_number = triangles_made;
        triangles_made    = triangles_made + 1'b1;
        pending_triangles.push_back(t);
    endtask

    // Advance the shadow state by one accepted vertex word
    task automatic assemble_vertex(input t_in_word w);
        if (w.starts_face) begin
            if (w.primitive_kind == KIND_LIST || w.primitive_kind == KIND_STRIP)
                face_kind = t_kind'(w.primitive_kind);
            else
                face_kind = KIND_OTHER;
            held_count   = 2'd0;
            keep_winding = 1'b1;
        end
        if (face_kind == KIND_LIST || face_kind == KIND_STRIP) begin
            if (held_count == 2'd0) begin
                held_older = w.vertex_index;
                held_count = 2'd1;
            end else if (held_count == 2'd1) begin
                held_newer = w.vertex_index;
                held_count = 2'd2;
            end else if (face_kind == KIND_LIST) begin
                close_triangle(held_older, held_newer, w.vertex_index);
                held_count = 2'd0;
            end else begin
                if (keep_winding)
                    close_triangle(held_older, held_newer, w.vertex_index);
                else
                    close_triangle(held_newer, held_older, w.vertex_index);
                held_older   = held_newer;
                held_newer   = w.vertex_index;
                keep_winding = ~keep_winding;
            end
        end
    endtask

    function automatic t_in_word make_word(input logic [INDEX_BITS-1:0] idx,
                                           input logic [1:0] kind,
                                           input logic start);
        t_in_word w;
        w.vertex_index   = idx;
        w.primitive_kind = kind;
        w.starts_face    = start;
        return w;
    endfunction

    // Drive one vertex word, idling at random first, and hold it until taken
    task automatic send_vertex(input t_in_word w);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        assemble_vertex(w);
    endtask

    // Check each accepted triangle and pick the next ready level
    always @(posedge i_clk) begin : check_triangles
        t_out_word want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_triangles.size() == 0) begin
                $error("triangle with no closing vertex: %h", out_word);
                mismatches++;
            end else begin
                want = pending_triangles.pop_front();
                if (out_word.corner_first !== want.corner_first) begin
                    $error("corner_first expected %0d got %0d",
                           want.corner_first, out_word.corner_first);
                    mismatches++;
                end
                if (out_word.corner_second !== want.corner_second) begin
                    $error("corner_second expected %0d got %0d",
                           want.corner_second, out_word.corner_second);
                    mismatches++;
                end
                if (out_word.corner_third !== want.corner_third) begin
                    $error("corner_third expected %0d got %0d",
                           want.corner_third, out_word.corner_third);
                    mismatches++;
                end
                if (out_word.triangle_number !== want.triangle_number) begin
                    $error("triangle_number expected %0d got %0d",
                           want.triangle_number, out_word.triangle_number);
                    mismatches++;
                end
            end
        end
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog: stop when no word moves for too long
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Vertices before any face start are dropped, whatever kind they carry
    task automatic test_before_first_face;
        send_vertex(make_word(20'd5, KIND_LIST, 1'b0));
        send_vertex(make_word(20'd6, KIND_STRIP, 1'b0));
    endtask

    // Lists: one triangle per three vertices, tails of two and one dropped
    task automatic test_list_faces;
        send_vertex(make_word(20'd0, KIND_LIST, 1'b1));
        send_vertex(make_word(INDEX_MAX, KIND_LIST, 1'b0));
        send_vertex(make_word(20'h5a5a5, KIND_LIST, 1'b0));
        send_vertex(make_word(20'h00001, KIND_LIST, 1'b0));
        send_vertex(make_word(20'h80000, KIND_LIST, 1'b0));
        send_vertex(make_word(INDEX_MAX, KIND_LIST, 1'b1));
        send_vertex(make_word(20'd0, KIND_LIST, 1'b0));
        send_vertex(make_word(20'ha5a5a, KIND_LIST, 1'b0));
        send_vertex(make_word(20'h12345, KIND_LIST, 1'b0));
    endtask

    // Strips: alternating winding, kind ignored inside the face, restart on new face
    task automatic test_strip_faces;
        send_vertex(make_word(20'd10, KIND_STRIP, 1'b1));
        send_vertex(make_word(20'd11, KIND_STRIP, 1'b0));
        send_vertex(make_word(20'd12, KIND_LIST, 1'b0));
        send_vertex(make_word(20'd13, KIND_OTHER, 1'b0));
        send_vertex(make_word(INDEX_MAX, KIND_UNUSED, 1'b0));
        send_vertex(make_word(20'd20, KIND_STRIP, 1'b1));
        send_vertex(make_word(20'd21, KIND_STRIP, 1'b0));
        send_vertex(make_word(20'd22, KIND_STRIP, 1'b0));
        send_vertex(make_word(20'd23, KIND_STRIP, 1'b0));
    endtask

    // Other kind and the unused code emit nothing
    task automatic test_other_kinds;
        send_vertex(make_word(20'd30, KIND_UNUSED, 1'b1));
        send_vertex(make_word(20'd31, KIND_STRIP, 1'b0));
        send_vertex(make_word(20'd32, KIND_OTHER, 1'b1));
        send_vertex(make_word(20'd33, KIND_LIST, 1'b0));
        send_vertex(make_word(20'd34, KIND_LIST, 1'b0));
    endtask

    // Mostly well-formed faces with random content, some raw noise words
    task automatic test_random_faces;
        int sent;
        int pick;
        int len;
        logic [1:0] kind;
        logic [INDEX_BITS-1:0] idx;
        t_in_word noise;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            no_idle = (sent >= 300 && sent < 450);
            pick = $urandom_range(99);
            if (pick < 8) begin
                noise = $bits(t_in_word)'($urandom);
                send_vertex(noise);
                sent++;
            end else begin
                if (pick < 48)
                    kind = KIND_LIST;
                else if (pick < 88)
                    kind = KIND_STRIP;
                else if (pick < 94)
                    kind = KIND_OTHER;
                else
                    kind = KIND_UNUSED;
                len = $urandom_range(1, 14);
                for (int k = 0; k < len; k++) begin
                    idx = INDEX_BITS'($urandom);
                    if ($urandom_range(19) == 0)
                        idx = $urandom_range(1) ? INDEX_MAX : '0;
                    send_vertex(make_word(idx, (k == 0) ? kind : 2'($urandom),
                                          k == 0));
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        held_older     = '0;
        held_newer     = '0;
        held_count     = 2'd0;
        keep_winding   = 1'b1;
        face_kind      = KIND_OTHER;
        triangles_made = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_before_first_face();
        test_list_faces();
        test_strip_faces();
        test_other_kinds();
        test_random_faces();

        // Drain the triangles still in flight
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_triangles.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
design/tpa_pkg.sv
design/tpa_step.sv
design/triangle_primitive_assembly_top.sv
tb/sv/tb_top.sv
